// File: src/dlcs_pkg.sv
`default_nettype none
package dlcs_pkg;

   localparam logic [2:0] REG_SECTOR_BYTES      = 3'd0;
   localparam logic [2:0] REG_SECTORS_PER_TRACK = 3'd1;
   localparam logic [2:0] REG_HEAD_COUNT        = 3'd2;
   localparam logic [2:0] REG_DRIVE_SELECT      = 3'd3;
   localparam logic [2:0] REG_DRIVE_ONLINE      = 3'd4;

   localparam logic [1:0] ST_ISSUED  = 2'd0;
   localparam logic [1:0] ST_OFFLINE = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;

   localparam logic [7:0] CMD_READ  = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;
   localparam logic [7:0] DH_FIXED  = 8'h20;

   localparam logic [12:0] BPS_MIN = 13'd128;
   localparam logic [12:0] BPS_MAX = 13'd4096;
   localparam logic [4:0]  HC_MAX  = 5'd16;
   localparam logic [5:0]  CNT_MAX = 6'd63;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] lblk;
      logic [5:0]  count;
      logic        mode;
   } item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] lblk;
      logic [5:0]  count;
      logic [15:0] cylinder;
      logic [7:0]  sector_number;
      logic [3:0]  head;
      logic [7:0]  drive_head_byte;
      logic [7:0]  command_code;
      logic        cylinder_overflow;
   } result_type;

endpackage
`default_nettype wire

// File: src/dlcs_div_pipe.sv
`default_nettype none
module dlcs_div_pipe #(
   parameter int NW    = 32,
   parameter int DW    = 13,
   parameter int LANES = 1,
   parameter int PW    = 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          in_valid,
   input  wire logic [LANES-1:0][NW-1:0]      in_num,
   input  wire logic [DW-1:0]                 in_den,
   input  wire logic [PW-1:0]                 in_pay,
   output logic                               out_valid,
   output logic [LANES-1:0][NW-1:0]           out_quo,
   output logic [LANES-1:0][DW-1:0]           out_rem,
   output logic [PW-1:0]                      out_pay
);

   logic                       valid_ff [1:NW];
   logic [LANES-1:0][NW-1:0]   num_ff   [1:NW];
   logic [LANES-1:0][DW-1:0]   rem_ff   [1:NW];
   logic [DW-1:0]              den_ff   [1:NW];
   logic [PW-1:0]              pay_ff   [1:NW];

   // one quotient bit per stage, restoring
   generate
      for (genvar s = 0; s < NW; s++) begin : g_stage
         logic                     cur_v;
         logic [LANES-1:0][NW-1:0] cur_num;
         logic [LANES-1:0][DW-1:0] cur_rem;
         logic [DW-1:0]            cur_den;
         logic [PW-1:0]            cur_pay;
         logic [LANES-1:0][NW-1:0] num_in;
         logic [LANES-1:0][DW-1:0] rem_in;

         if (s == 0) begin : g_first
            assign cur_v   = in_valid;
            assign cur_num = in_num;
            assign cur_rem = '0;
            assign cur_den = in_den;
            assign cur_pay = in_pay;
         end else begin : g_next
            assign cur_v   = valid_ff[s];
            assign cur_num = num_ff[s];
            assign cur_rem = rem_ff[s];
            assign cur_den = den_ff[s];
            assign cur_pay = pay_ff[s];
         end

         always_comb begin
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
               trial = {cur_rem[l], cur_num[l][NW-1]};
               diff  = trial - {1'b0, cur_den};
               ge    = (trial >= {1'b0, cur_den});
               rem_in[l] = ge ? diff[DW-1:0] : trial[DW-1:0];
               num_in[l] = {cur_num[l][NW-2:0], ge};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s+1] <= 1'b0;
            end else if (en) begin
               valid_ff[s+1] <= cur_v;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[s+1] <= num_in;
               rem_ff[s+1] <= rem_in;
               den_ff[s+1] <= cur_den;
               pay_ff[s+1] <= cur_pay;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NW];
   assign out_quo   = num_ff[NW];
   assign out_rem   = rem_ff[NW];
   assign out_pay   = pay_ff[NW];

endmodule
`default_nettype wire

// File: src/dlcs_front.sv
`default_nettype none
module dlcs_front #(
   parameter int MAX_XFER = 4096
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              mode,
   input  wire logic [31:0]       part_start,
   input  wire logic [31:0]       part_end,
   input  wire logic [31:0]       byte_offset,
   input  wire logic [30:0]       byte_length,
   input  wire logic [12:0]       bps,
   input  wire logic              online,
   input  wire logic              q_full,
   output logic                   q_wr,
   output dlcs_pkg::item_type     q_item
);

   localparam int LW = $clog2(MAX_XFER + 1);
   localparam int PW = 65;

   logic                 en;
   logic [LW-1:0]        blen_c;
   logic [1:0][31:0]     d_num;
   logic                 d_v;
   logic [1:0][31:0]     d_quo;
   logic [1:0][12:0]     d_rem;
   logic [PW-1:0]        d_pay;

   logic                 f1_v_ff;
   logic [32:0]          f1_lblk_ff;
   logic [LW-1:0]        f1_cnt_ff;
   logic [31:0]          f1_pend_ff;
   logic                 f1_mode_ff;

   logic                 f2_v_ff;
   dlcs_pkg::item_type   f2_item_ff;
   dlcs_pkg::item_type   f2_item_in;

   logic [31:0]          room;
   logic [LW-1:0]        cnt_clip;

   assign en       = !(f2_v_ff && q_full);
   assign in_ready = en;
   assign q_wr     = f2_v_ff && !q_full;
   assign q_item   = f2_item_ff;

   assign blen_c = (byte_length > 31'(MAX_XFER)) ? LW'(MAX_XFER) : byte_length[LW-1:0];
   assign d_num  = {32'(blen_c), byte_offset};

   dlcs_div_pipe #(.NW(32), .DW(13), .LANES(2), .PW(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (in_valid),
      .in_num   (d_num),
      .in_den   (bps),
      .in_pay   ({mode, part_start, part_end}),
      .out_valid(d_v),
      .out_quo  (d_quo),
      .out_rem  (d_rem),
      .out_pay  (d_pay)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= d_v;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_lblk_ff <= {1'b0, d_quo[0]} + {1'b0, d_pay[63:32]};
         f1_cnt_ff  <= d_quo[1][LW-1:0] + LW'(d_rem[1] != '0);
         f1_pend_ff <= d_pay[31:0];
         f1_mode_ff <= d_pay[64];
         f2_item_ff <= f2_item_in;
      end
   end

   assign room     = f1_pend_ff - f1_lblk_ff[31:0];
   assign cnt_clip = (32'(f1_cnt_ff) > room) ? LW'(room) : f1_cnt_ff;

   always_comb begin
      f2_item_in.lblk  = f1_lblk_ff[31:0];
      f2_item_in.mode  = f1_mode_ff;
      f2_item_in.count = (cnt_clip > LW'(dlcs_pkg::CNT_MAX)) ? dlcs_pkg::CNT_MAX
                                                              : cnt_clip[5:0];
      priority if (!online) begin
         f2_item_in.status = dlcs_pkg::ST_OFFLINE;
      end else if (f1_cnt_ff == '0) begin
         f2_item_in.status = dlcs_pkg::ST_EMPTY;
      end else if (f1_lblk_ff >= {1'b0, f1_pend_ff}) begin
         f2_item_in.status = dlcs_pkg::ST_EMPTY;
      end else begin
         f2_item_in.status = dlcs_pkg::ST_ISSUED;
      end
   end

endmodule
`default_nettype wire

// File: src/dlcs_fifo.sv
`default_nettype none
module dlcs_fifo #(
   parameter int DEPTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr,
   input  wire dlcs_pkg::item_type wr_item,
   output logic                    full,
   input  wire logic               rd,
   output logic                    rd_valid,
   output dlcs_pkg::item_type      rd_item
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dlcs_pkg::item_type mem_ff [DEPTH];
   logic [AW-1:0]      wp_ff;
   logic [AW-1:0]      rp_ff;
   logic [CW-1:0]      cnt_ff;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_item  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) begin
            wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (rd) begin
            rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + CW'(wr) - CW'(rd);
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_item;
      end
   end

endmodule
`default_nettype wire

// File: src/dlcs_back.sv
`default_nettype none
module dlcs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire dlcs_pkg::item_type q_item,
   output logic                    q_rd,
   input  wire logic [7:0]         spt,
   input  wire logic [4:0]         hc,
   input  wire logic               drive_select,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output dlcs_pkg::result_type    out_res
);

   localparam int IW = $bits(dlcs_pkg::item_type);

   logic                  en;
   logic                  a_v;
   logic [0:0][31:0]      a_quo;
   logic [0:0][7:0]       a_rem;
   logic [IW-1:0]         a_pay;
   logic                  b_v;
   logic [0:0][31:0]      b_quo;
   logic [0:0][4:0]       b_rem;
   logic [IW+7:0]         b_pay;
   dlcs_pkg::item_type    b_item;
   logic [7:0]            b_sec;

   logic                  out_v_ff;
   dlcs_pkg::result_type  res_ff;
   dlcs_pkg::result_type  res_in;

   assign en        = !out_v_ff || out_ready;
   assign q_rd      = en && q_valid;
   assign out_valid = out_v_ff;
   assign out_res   = res_ff;

   // block / spt gives sector and track; track / heads gives cylinder and head
   dlcs_div_pipe #(.NW(32), .DW(8), .LANES(1), .PW(IW)) u_div_spt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (q_valid),
      .in_num   (q_item.lblk),
      .in_den   (spt),
      .in_pay   (q_item),
      .out_valid(a_v),
      .out_quo  (a_quo),
      .out_rem  (a_rem),
      .out_pay  (a_pay)
   );

   dlcs_div_pipe #(.NW(32), .DW(5), .LANES(1), .PW(IW + 8)) u_div_hc (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (a_v),
      .in_num   (a_quo),
      .in_den   (hc),
      .in_pay   ({a_pay, a_rem[0]}),
      .out_valid(b_v),
      .out_quo  (b_quo),
      .out_rem  (b_rem),
      .out_pay  (b_pay)
   );

   assign b_item = b_pay[IW+7:8];
   assign b_sec  = b_pay[7:0];

   always_comb begin
      res_in = '0;
      res_in.status = b_item.status;
      if (b_item.status == dlcs_pkg::ST_ISSUED) begin
         res_in.lblk              = b_item.lblk;
         res_in.count             = b_item.count;
         res_in.cylinder          = b_quo[0][15:0];
         res_in.sector_number     = b_sec + 8'd1;
         res_in.head              = b_rem[0][3:0];
         res_in.drive_head_byte   = dlcs_pkg::DH_FIXED | {3'b000, drive_select, b_rem[0][3:0]};
         res_in.command_code      = b_item.mode ? dlcs_pkg::CMD_WRITE : dlcs_pkg::CMD_READ;
         res_in.cylinder_overflow = (b_quo[0][31:16] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= b_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

endmodule
`default_nettype wire

// File: src/disk_lba_to_chs_command_setup.sv
// ATA task-file setup: byte request within a partition -> LBA, count, CHS, command.
// req_ channel: one request item per transfer. rsp_ channel: exactly one result
// item per request, in request order. csr_ port writes the geometry and drive
// registers by index; write them only while no request is in flight.
// The path is a 32-stage offset/length divider by the sector size, two stages
// for block sum and partition checks, the queue, then two 32-stage dividers (by
// sectors per track, then by heads), and the output register. One item per
// cycle is taken and delivered when both sides keep up; each divider stage
// retires one quotient bit.
// If rsp_tready is low, the back part holds and the queue fills; once the queue
// is full, the front part holds and req_tready falls. The front keeps accepting
// while a result waits, up to the queue depth plus the front pipeline.
// Reset clears all pipeline valid bits and the queue and loads the register
// defaults: 512-byte sectors, 63 sectors per track, 16 heads, drive 0, offline.
// Offline, zero-length and beyond-partition requests return an error status
// with all other fields zero.
`default_nettype none
module disk_lba_to_chs_command_setup #(
   parameter int MAX_XFER    = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // mode[0], part_start[32:1], part_end[64:33], byte_offset[96:65], byte_length[127:97]
   input  wire logic [127:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // status[1:0], logical_block[33:2], sector_count[39:34], cylinder[55:40],
   // sector_number[63:56], head[67:64], drive_head_byte[75:68],
   // command_code[83:76], cylinder_overflow[84], zero[87:85]
   output logic [87:0]        rsp_tdata,
   input  wire logic          csr_we,
   input  wire logic [2:0]    csr_index,
   input  wire logic [12:0]   csr_wdata
);

   logic [12:0]          sector_bytes_ff;
   logic [7:0]           spt_ff;
   logic [4:0]           head_count_ff;
   logic                 drive_select_ff;
   logic                 drive_online_ff;

   logic [12:0]          bps;
   logic [7:0]           spt;
   logic [4:0]           hc;

   logic                 q_wr;
   logic                 q_full;
   logic                 q_rd;
   logic                 q_valid;
   dlcs_pkg::item_type   q_wr_item;
   dlcs_pkg::item_type   q_rd_item;
   dlcs_pkg::result_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_bytes_ff <= 13'd512;
         spt_ff          <= 8'd63;
         head_count_ff   <= 5'd16;
         drive_select_ff <= 1'b0;
         drive_online_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            dlcs_pkg::REG_SECTOR_BYTES:      sector_bytes_ff <= csr_wdata;
            dlcs_pkg::REG_SECTORS_PER_TRACK: spt_ff          <= csr_wdata[7:0];
            dlcs_pkg::REG_HEAD_COUNT:        head_count_ff   <= csr_wdata[4:0];
            dlcs_pkg::REG_DRIVE_SELECT:      drive_select_ff <= csr_wdata[0];
            dlcs_pkg::REG_DRIVE_ONLINE:      drive_online_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign bps = (sector_bytes_ff < dlcs_pkg::BPS_MIN) ? dlcs_pkg::BPS_MIN :
                (sector_bytes_ff > dlcs_pkg::BPS_MAX) ? dlcs_pkg::BPS_MAX : sector_bytes_ff;
   assign spt = (spt_ff == '0) ? 8'd1 : spt_ff;
   assign hc  = (head_count_ff == '0) ? 5'd1 :
                (head_count_ff > dlcs_pkg::HC_MAX) ? dlcs_pkg::HC_MAX : head_count_ff;

   dlcs_front #(.MAX_XFER(MAX_XFER)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .mode        (req_tdata[0]),
      .part_start  (req_tdata[32:1]),
      .part_end    (req_tdata[64:33]),
      .byte_offset (req_tdata[96:65]),
      .byte_length (req_tdata[127:97]),
      .bps         (bps),
      .online      (drive_online_ff),
      .q_full      (q_full),
      .q_wr        (q_wr),
      .q_item      (q_wr_item)
   );

   dlcs_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (q_wr),
      .wr_item  (q_wr_item),
      .full     (q_full),
      .rd       (q_rd),
      .rd_valid (q_valid),
      .rd_item  (q_rd_item)
   );

   dlcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_item       (q_rd_item),
      .q_rd         (q_rd),
      .spt          (spt),
      .hc           (hc),
      .drive_select (drive_select_ff),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_res      (res)
   );

   assign rsp_tdata = {3'b000, res.cylinder_overflow, res.command_code, res.drive_head_byte,
                       res.head, res.sector_number, res.cylinder, res.count, res.lblk,
                       res.status};

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.status != dlcs_pkg::ST_ISSUED) |->
         (res.lblk == '0 && res.count == '0 && res.command_code == '0))
      else $error("error result carries nonzero fields");

   a_chs_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.status == dlcs_pkg::ST_ISSUED) |->
         (res.sector_number != '0 && res.sector_number <= spt && {1'b0, res.head} < hc
          && res.count != '0))
      else $error("issued result out of geometry");

   a_queue_hold : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_wr)
      else $error("queue written while full");

endmodule
`default_nettype wire
